FILE: hw/rtl/kvl_pkg.sv
`timescale 1ns / 1ps

package kvl_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int KEY_IDX_W = $clog2(MAX_KEYS);
	localparam int CNT_W     = $clog2(MAX_KEYS + 1);
	// fraction is Q0.16 in 0..65536, so one extra bit
	localparam int FRAC_W    = 17;
	localparam int LANE_LAT  = 4;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic [5:0]         key_index;
		logic [31:0]        key_time;
		logic signed [31:0] key_x;
		logic signed [31:0] key_y;
		logic signed [31:0] key_z;
		logic [31:0]        sample_time;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               empty_error;
	} out_item_t;

	// outcome of the key search
	typedef struct packed {
		logic [KEY_IDX_W-1:0] i0;
		logic [KEY_IDX_W-1:0] i1;
		logic                 pair;
		logic [31:0]          t0;
		logic [31:0]          t1;
	} srch_res_t;

	typedef enum logic [1:0] {
		SRCH_IDLE,
		SRCH_ISSUE,
		SRCH_FIRST,
		SRCH_SCAN
	} srch_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DIV,
		ST_LERP,
		ST_EMIT
	} core_state_t;

endpackage

FILE: hw/rtl/kvl_search.sv
`timescale 1ns / 1ps

module kvl_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [kvl_pkg::KEY_IDX_W-1:0]  wr_addr,
	input  logic [31:0]                    wr_time,
	input  logic                           start,
	input  logic [31:0]                    sample_time,
	input  logic [kvl_pkg::CNT_W-1:0]      n,
	output logic                           done,
	output kvl_pkg::srch_res_t             res
);

	logic [31:0] tmem [kvl_pkg::MAX_KEYS];
	logic [31:0] rd_q;
	logic [31:0] prev_q;
	logic [kvl_pkg::CNT_W-1:0] idx_q;
	logic [kvl_pkg::CNT_W-1:0] cur;
	kvl_pkg::srch_state_t state_q, state_d;
	kvl_pkg::srch_res_t res_d, res_q;
	logic first_hit, pair_hit, last, fin;
	logic done_q;

	// rd_q holds t[idx_q-1]; prev_q holds t[idx_q-2]
	assign cur       = idx_q - kvl_pkg::CNT_W'(1);
	assign first_hit = (n == kvl_pkg::CNT_W'(1)) || (sample_time <= rd_q);
	assign pair_hit  = (prev_q <= sample_time) && (sample_time <= rd_q);
	assign last      = (cur == n - kvl_pkg::CNT_W'(1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kvl_pkg::SRCH_IDLE:  if (start) state_d = kvl_pkg::SRCH_ISSUE;
			kvl_pkg::SRCH_ISSUE: state_d = kvl_pkg::SRCH_FIRST;
			kvl_pkg::SRCH_FIRST: state_d = first_hit ? kvl_pkg::SRCH_IDLE : kvl_pkg::SRCH_SCAN;
			kvl_pkg::SRCH_SCAN:  if (pair_hit || last) state_d = kvl_pkg::SRCH_IDLE;
			default:             state_d = kvl_pkg::SRCH_IDLE;
		endcase
	end

	always_comb begin
		fin        = 1'b0;
		res_d.i0   = '0;
		res_d.i1   = '0;
		res_d.pair = 1'b0;
		res_d.t0   = prev_q;
		res_d.t1   = rd_q;
		unique case (state_q)
			kvl_pkg::SRCH_FIRST: fin = first_hit;
			kvl_pkg::SRCH_SCAN: begin
				fin = pair_hit || last;
				if (pair_hit) begin
					res_d.i0   = kvl_pkg::KEY_IDX_W'(cur - kvl_pkg::CNT_W'(1));
					res_d.i1   = kvl_pkg::KEY_IDX_W'(cur);
					res_d.pair = 1'b1;
				end else begin
					// past the last key: hold the last value
					res_d.i0 = kvl_pkg::KEY_IDX_W'(cur);
					res_d.i1 = kvl_pkg::KEY_IDX_W'(cur);
				end
			end
			default: fin = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) tmem[wr_addr] <= wr_time;
		rd_q <= tmem[idx_q[kvl_pkg::KEY_IDX_W-1:0]];
		if (state_q == kvl_pkg::SRCH_FIRST || state_q == kvl_pkg::SRCH_SCAN) prev_q <= rd_q;
		if (fin) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kvl_pkg::SRCH_IDLE;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == kvl_pkg::SRCH_IDLE) idx_q <= '0;
			else idx_q <= idx_q + kvl_pkg::CNT_W'(1);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

FILE: hw/rtl/kvl_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle; dividend is shifted up by 16
module kvl_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [31:0]                   dividend,
	input  logic [31:0]                   divisor,
	output logic                          done,
	output logic [kvl_pkg::FRAC_W-1:0]    quo
);

	localparam int STEP_W = $clog2(kvl_pkg::FRAC_W + 1);

	logic [32:0] rem_q;
	logic [31:0] den_q;
	logic [kvl_pkg::FRAC_W-1:0] quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic done_q;
	logic busy, ge;
	logic [32:0] rem_sub;

	assign busy    = (cnt_q != '0);
	assign ge      = (rem_q >= {1'b0, den_q});
	assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			den_q <= divisor;
			quo_q <= '0;
		end else if (busy) begin
			// remainder stays below the divisor, so 32 bits survive the shift
			rem_q <= {rem_sub[31:0], 1'b0};
			quo_q <= {quo_q[kvl_pkg::FRAC_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == STEP_W'(1));
			if (start) cnt_q <= STEP_W'(kvl_pkg::FRAC_W);
			else if (busy) cnt_q <= cnt_q - STEP_W'(1);
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hw/rtl/kvl_lane.sv
`timescale 1ns / 1ps

// one vector component: value store and v0 + floor((v1 - v0) * f / 2^16)
module kvl_lane (
	input  logic                          clk,
	input  logic                          we,
	input  logic [kvl_pkg::KEY_IDX_W-1:0] waddr,
	input  logic signed [31:0]            wdata,
	input  logic [kvl_pkg::KEY_IDX_W-1:0] raddr0,
	input  logic [kvl_pkg::KEY_IDX_W-1:0] raddr1,
	input  logic [kvl_pkg::FRAC_W-1:0]    frac,
	output logic signed [31:0]            result
);

	logic signed [31:0] vmem [kvl_pkg::MAX_KEYS];
	logic signed [31:0] v0_s1, v1_s1, v0_s2, v0_s3, res_s4;
	logic signed [32:0] diff_s2;
	logic signed [kvl_pkg::FRAC_W+33:0] prod_s3;

	always_ff @(posedge clk) begin
		if (we) vmem[waddr] <= wdata;
		v0_s1   <= vmem[raddr0];
		v1_s1   <= vmem[raddr1];
		v0_s2   <= v0_s1;
		diff_s2 <= {v1_s1[31], v1_s1} - {v0_s1[31], v0_s1};
		v0_s3   <= v0_s2;
		prod_s3 <= diff_s2 * $signed({1'b0, frac});
		// arithmetic shift by 16 floors; wraps mod 2^32 with the add
		res_s4  <= v0_s3 + prod_s3[47:16];
	end

	assign result = res_s4;

endmodule

FILE: hw/rtl/keyframe_vector_lerp_sampler_core.sv
`timescale 1ns / 1ps

// channel  | dir | payload              | handshake
// ---------+-----+----------------------+----------------------------
// in       | in  | kvl_pkg::in_item_t   | in_valid / in_stall
// out      | out | kvl_pkg::out_item_t  | out_valid / out_stall
// cfg      | in  | cfg_data (key_count) | cfg_we, no wait
//
// A key write does not stall the input. A sample runs the key search, then the serial
// divider when two keys with distinct times bracket the time, then the lane pipeline, and
// then loads the output register; the input stays stalled until the core is idle again.
// Reset clears control state and key_count; stores hold garbage until written.
// in_stall is high while a sample is in flight; a result waiting on out_stall
// does not block the next beat in.
module keyframe_vector_lerp_sampler_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [6:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  kvl_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output kvl_pkg::out_item_t  out_data
);

	kvl_pkg::core_state_t state_q, state_d;
	logic [6:0] key_count_q;
	logic [kvl_pkg::CNT_W-1:0] n_clamp, n_q;
	logic [31:0] t_q;
	logic err_q;
	logic [kvl_pkg::FRAC_W-1:0] f_q;
	logic [2:0] lat_q;
	logic out_valid_q;
	kvl_pkg::out_item_t out_q;

	logic acc, is_wr, is_smp, key_we;
	logic srch_start, srch_done;
	kvl_pkg::srch_res_t srch_res;
	logic div_start, div_done, zero_span;
	logic [kvl_pkg::FRAC_W-1:0] div_quo;
	logic emit_go;
	logic signed [31:0] lane_x, lane_y, lane_z;
	logic [kvl_pkg::KEY_IDX_W-1:0] waddr;

	assign acc     = in_valid && !in_stall;
	assign is_wr   = acc && (in_data.opcode == kvl_pkg::OP_WRITE);
	assign is_smp  = acc && (in_data.opcode == kvl_pkg::OP_SAMPLE);
	assign key_we  = is_wr && (int'(in_data.key_index) < kvl_pkg::MAX_KEYS);
	assign waddr   = kvl_pkg::KEY_IDX_W'(in_data.key_index);
	assign n_clamp = (int'(key_count_q) > kvl_pkg::MAX_KEYS) ?
		kvl_pkg::CNT_W'(kvl_pkg::MAX_KEYS) : kvl_pkg::CNT_W'(key_count_q);
	assign zero_span = (srch_res.t1 == srch_res.t0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kvl_pkg::ST_IDLE: begin
				if (is_smp) state_d = (n_clamp == '0) ? kvl_pkg::ST_EMIT : kvl_pkg::ST_SEARCH;
			end
			kvl_pkg::ST_SEARCH: begin
				if (srch_done)
					state_d = (srch_res.pair && !zero_span) ? kvl_pkg::ST_DIV : kvl_pkg::ST_LERP;
			end
			kvl_pkg::ST_DIV:  if (div_done) state_d = kvl_pkg::ST_LERP;
			kvl_pkg::ST_LERP: if (lat_q == 3'd1) state_d = kvl_pkg::ST_EMIT;
			kvl_pkg::ST_EMIT: if (emit_go) state_d = kvl_pkg::ST_IDLE;
			default:          state_d = kvl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall   = (state_q != kvl_pkg::ST_IDLE);
		srch_start = is_smp && (n_clamp != '0);
		div_start  = (state_q == kvl_pkg::ST_SEARCH) && srch_done && srch_res.pair && !zero_span;
		emit_go    = (state_q == kvl_pkg::ST_EMIT) && (!out_valid_q || !out_stall);
	end

	kvl_search u_search (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (key_we),
		.wr_addr     (waddr),
		.wr_time     (in_data.key_time),
		.start       (srch_start),
		.sample_time (t_q),
		.n           (n_q),
		.done        (srch_done),
		.res         (srch_res)
	);

	kvl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (t_q - srch_res.t0),
		.divisor  (srch_res.t1 - srch_res.t0),
		.done     (div_done),
		.quo      (div_quo)
	);

	kvl_lane u_lane_x (
		.clk (clk), .we (key_we), .waddr (waddr), .wdata (in_data.key_x),
		.raddr0 (srch_res.i0), .raddr1 (srch_res.i1), .frac (f_q), .result (lane_x)
	);

	kvl_lane u_lane_y (
		.clk (clk), .we (key_we), .waddr (waddr), .wdata (in_data.key_y),
		.raddr0 (srch_res.i0), .raddr1 (srch_res.i1), .frac (f_q), .result (lane_y)
	);

	kvl_lane u_lane_z (
		.clk (clk), .we (key_we), .waddr (waddr), .wdata (in_data.key_z),
		.raddr0 (srch_res.i0), .raddr1 (srch_res.i1), .frac (f_q), .result (lane_z)
	);

	always_ff @(posedge clk) begin
		if (is_smp) t_q <= in_data.sample_time;
		if ((state_q == kvl_pkg::ST_SEARCH) && srch_done) f_q <= '0;
		else if (div_done) f_q <= div_quo;
		// merge the three lanes into one result beat
		if (emit_go) begin
			out_q.out_x       <= err_q ? '0 : lane_x;
			out_q.out_y       <= err_q ? '0 : lane_y;
			out_q.out_z       <= err_q ? '0 : lane_z;
			out_q.empty_error <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kvl_pkg::ST_IDLE;
			key_count_q <= '0;
			n_q         <= '0;
			err_q       <= 1'b0;
			lat_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) key_count_q <= cfg_data;
			if (is_smp) begin
				n_q   <= n_clamp;
				err_q <= (n_clamp == '0);
			end
			if (state_q != kvl_pkg::ST_LERP && state_d == kvl_pkg::ST_LERP)
				lat_q <= 3'(kvl_pkg::LANE_LAT);
			else if (lat_q != '0)
				lat_q <= lat_q - 3'd1;
			if (emit_go) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: hw/rtl/kvl_checker.sv
`timescale 1ns / 1ps

module kvl_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  kvl_pkg::in_item_t   in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  kvl_pkg::out_item_t  out_data
);

	// a held result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output beat changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.empty_error |->
			out_data.out_x == 0 && out_data.out_y == 0 && out_data.out_z == 0)
		else $error("empty table result carries a nonzero vector");

	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.opcode == kvl_pkg::OP_WRITE |=> !in_stall)
		else $error("key write left the input stalled");

	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.opcode == kvl_pkg::OP_SAMPLE |=> in_stall)
		else $error("sample accepted without going busy");

	a_result_ends: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $fell(in_stall))
		else $error("result beat appeared outside the end of a sample");

endmodule

bind keyframe_vector_lerp_sampler_core kvl_checker u_kvl_checker (.*);

FILE: tb/tb_keyframe_vector_lerp_sampler_core.sv
`timescale 1ns / 1ps

module tb_keyframe_vector_lerp_sampler_core;
	import kvl_pkg::*;

	localparam int STUCK_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int ITEM_TARGET = 1150;

	// Keyframe table shadow plus the queue of vectors it should produce
	class keyframe_track;
		logic [6:0]         key_count;
		logic [31:0]        t_mem[MAX_KEYS];
		logic signed [31:0] x_mem[MAX_KEYS];
		logic signed [31:0] y_mem[MAX_KEYS];
		logic signed [31:0] z_mem[MAX_KEYS];
		out_item_t          pending_vectors[$];
		int errors, checked, n_samples, n_writes, n_empty, n_interp;

		function new();
			key_count = '0;
			errors = 0;
			checked = 0;
			n_samples = 0;
			n_writes = 0;
			n_empty = 0;
			n_interp = 0;
		endfunction

		function logic signed [31:0] blend(logic signed [31:0] a, logic signed [31:0] b,
				logic [16:0] f);
			longint d, p, r;
			d = longint'(b) - longint'(a);
			p = d * longint'(f);
			r = longint'(a) + (p >>> 16);
			return r[31:0];
		endfunction

		function out_item_t vector_at(int i, int j, logic [16:0] f);
			out_item_t v;
			v.out_x = blend(x_mem[i], x_mem[j], f);
			v.out_y = blend(y_mem[i], y_mem[j], f);
			v.out_z = blend(z_mem[i], z_mem[j], f);
			v.empty_error = 1'b0;
			return v;
		endfunction

		function out_item_t interpolate(logic [31:0] ts);
			int n;
			logic [63:0] num;
			logic [31:0] t0, t1;
			logic [16:0] f;
			out_item_t v;
			n = (key_count > MAX_KEYS) ? MAX_KEYS : key_count;
			if (n == 0) begin
				n_empty++;
				v = '0;
				v.empty_error = 1'b1;
				return v;
			end
			if (n == 1 || ts <= t_mem[0])
				return vector_at(0, 0, '0);
			for (int i = 0; i + 1 < n; i++) begin
				t0 = t_mem[i];
				t1 = t_mem[i + 1];
				if (t0 <= ts && ts <= t1) begin
					f = '0;
					if (t1 != t0) begin
						num = {32'b0, ts - t0} << 16;
						f = 17'(num / {32'b0, t1 - t0});
						n_interp++;
					end
					return vector_at(i, i + 1, f);
				end
			end
			return vector_at(n - 1, n - 1, '0);
		endfunction

		function void note_input(in_item_t it);
			if (it.opcode == OP_WRITE) begin
				t_mem[it.key_index] = it.key_time;
				x_mem[it.key_index] = it.key_x;
				y_mem[it.key_index] = it.key_y;
				z_mem[it.key_index] = it.key_z;
				n_writes++;
			end else begin
				pending_vectors.insert(pending_vectors.size(), interpolate(it.sample_time));
				n_samples++;
			end
		endfunction

		task report(string field, logic [31:0] got, logic [31:0] want);
			errors++;
			if (errors <= 100)
				$display("mismatch on result %0d, %s: got %h, want %h", checked, field, got,
					want);
		endtask

		task check(out_item_t got);
			out_item_t want;
			if (pending_vectors.size() == 0) begin
				report("unexpected beat", got.out_x, '0);
				return;
			end
			want = pending_vectors.pop_front();
			if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
			if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
			if (got.out_z !== want.out_z) report("out_z", got.out_z, want.out_z);
			if (got.empty_error !== want.empty_error)
				report("empty_error", {31'b0, got.empty_error}, {31'b0, want.empty_error});
			checked++;
		endtask

		function bit waiting();
			return pending_vectors.size() != 0;
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [6:0] cfg_data;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_data;

	keyframe_track track;
	bit quiet;
	bit hold_req;
	int beats_sent;
	int settings_seen;
	int stuck;

	keyframe_vector_lerp_sampler_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic in_item_t noise_item();
		in_item_t it;
		it.opcode = opcode_t'($urandom_range(1));
		it.key_index = 6'($urandom);
		it.key_time = $urandom;
		it.key_x = $urandom;
		it.key_y = $urandom;
		it.key_z = $urandom;
		it.sample_time = $urandom;
		return it;
	endfunction

	function automatic logic [31:0] rand_val();
		case ($urandom_range(7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_beat(input in_item_t it);
		if (!quiet && $urandom_range(99) < 7) begin
			@(negedge clk);
			in_valid <= 1'b0;
			in_data <= noise_item();
			repeat ($urandom_range(3)) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		track.note_input(it);
		beats_sent++;
	endtask

	task automatic write_key(input int slot, input logic [31:0] kt, input logic [31:0] kx,
			input logic [31:0] ky, input logic [31:0] kz);
		in_item_t it;
		it = noise_item();
		it.opcode = OP_WRITE;
		it.key_index = 6'(slot);
		it.key_time = kt;
		it.key_x = kx;
		it.key_y = ky;
		it.key_z = kz;
		push_beat(it);
	endtask

	task automatic sample_at(input logic [31:0] ts);
		in_item_t it;
		it = noise_item();
		it.opcode = OP_SAMPLE;
		it.sample_time = ts;
		push_beat(it);
	endtask

	// sender stops and waits for every outstanding vector
	task automatic drain_all(input int settle);
		@(negedge clk);
		in_valid <= 1'b0;
		while (track.waiting()) @(posedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic set_key_count(input logic [6:0] v);
		drain_all(8);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_data <= 7'($urandom);
		track.key_count = v;
		settings_seen++;
	endtask

	// well-formed track: nondecreasing times in slots 0..m-1
	task automatic load_sorted(input int m);
		logic [31:0] base;
		base = $urandom_range(0, 32'h0010_0000);
		for (int i = 0; i < m; i++) begin
			if (i == m - 1 && m > 1 && $urandom_range(3) == 0)
				write_key(i, '1, rand_val(), rand_val(), rand_val());
			else
				write_key(i, base, rand_val(), rand_val(), rand_val());
			if ($urandom_range(5) != 0)
				base += $urandom_range(1, 32'h0008_0000);
		end
	endtask

	function automatic logic [31:0] pick_time(int m);
		logic [31:0] lo, hi;
		logic [63:0] span;
		int s;
		s = (m > 0) ? $urandom_range(m - 1) : 0;
		lo = track.t_mem[0];
		hi = track.t_mem[(m > 0) ? m - 1 : 0];
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return track.t_mem[s];
			4: return track.t_mem[s] + $urandom_range(2) - 1;
			5: return $urandom;
			default: begin
				if (hi <= lo)
					return $urandom;
				span = {32'b0, hi - lo} + 64'd1;
				return lo + 32'({32'b0, $urandom} % span);
			end
		endcase
	endfunction

	// receiver: random stall, or one long hold-off when asked
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 7);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			track.check(out_data);

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck == STUCK_LIMIT) begin
				$display("watchdog: no beat for %0d cycles", STUCK_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		int plan[10];
		int n, m, phase, per_phase;
		track = new();
		plan = '{2, 64, 127, 1, 5, 0, 9, 17, 33, 3};
		quiet = 1'b0;
		hold_req = 1'b0;
		beats_sent = 0;
		settings_seen = 0;
		stuck = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table straight after reset
		sample_at('0);
		sample_at('1);
		// unordered times with a repeated time and extreme vectors
		write_key(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		write_key(1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		write_key(2, 32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF);
		write_key(3, 32'h0002_0000, 32'h1234_5678, 32'h8000_0000, 32'h8000_0000);
		write_key(4, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
		sample_at(32'h0002_0000);
		set_key_count(7'd1);
		sample_at('1);
		set_key_count(7'd5);
		sample_at('0);
		sample_at(32'h0001_0000);
		sample_at(32'h0001_8000);
		sample_at(32'h0003_0000);
		sample_at(32'h0002_8000);
		sample_at(32'h0003_0001);
		sample_at(32'hFFFF_FFFE);
		sample_at('1);
		drain_all(8);

		// every slot gets written once before larger counts are used
		load_sorted(MAX_KEYS);

		phase = 0;
		while (beats_sent < ITEM_TARGET) begin
			if (phase < 10)
				n = plan[phase];
			else if ($urandom_range(7) == 0)
				n = $urandom_range(0, 127);
			else
				n = $urandom_range(1, 12);
			m = (n > MAX_KEYS) ? MAX_KEYS : n;
			set_key_count(7'(n));
			quiet = (phase == 3 || phase == 4);
			if (m > 0 && $urandom_range(3) != 0)
				load_sorted(m);
			if (phase == 2)
				hold_req = 1'b1;
			per_phase = (m > 32) ? 40 : 80;
			repeat (per_phase) begin
				if ($urandom_range(99) < 85) begin
					sample_at(pick_time(m));
				end else begin
					int slot;
					slot = $urandom_range(MAX_KEYS - 1);
					// mostly new vectors at the same time; sometimes break the order
					if ($urandom_range(2) == 0)
						write_key(slot, $urandom, rand_val(), rand_val(), rand_val());
					else
						write_key(slot, track.t_mem[slot], rand_val(), rand_val(), rand_val());
				end
			end
			phase++;
		end

		drain_all(120);
		$display("covered %0d samples (%0d interpolated, %0d on an empty table) and %0d key writes",
			track.n_samples, track.n_interp, track.n_empty, track.n_writes);
		$display("across %0d key count settings, %0d vectors checked", settings_seen,
			track.checked);
		if (track.errors == 0 && !track.waiting())
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/kvl_pkg.sv
hw/rtl/kvl_search.sv
hw/rtl/kvl_div.sv
hw/rtl/kvl_lane.sv
hw/rtl/keyframe_vector_lerp_sampler_core.sv
hw/rtl/kvl_checker.sv
tb/tb_keyframe_vector_lerp_sampler_core.sv
